/* rtl/core/hhs_pkg.sv */
// Shared types and constants of the heavy-hitter sketch insert block.
`timescale 1ns / 1ps
package hhs_pkg;
    localparam logic [31:0] C1 = 32'hcc9e2d51;
    localparam logic [31:0] C2 = 32'h1b873593;
    localparam logic [31:0] C3 = 32'he6546b64;
    localparam logic [31:0] C4 = 32'h85ebca6b;
    localparam logic [31:0] C5 = 32'hc2b2ae35;
    localparam logic [31:0] COUNT_MAX = 32'hffffffff;
    localparam logic [2:0] REG_ROW_SIZE = 3'd0;
    localparam logic [2:0] REG_SEED0 = 3'd1;
    localparam logic [2:0] REG_SEED3 = 3'd4;
    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_READ = 1'b1;

    typedef struct packed {
        logic [31:0] item;
        logic [31:0] count;
    } bucket_t;
endpackage

/* rtl/core/hhs_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read.
`timescale 1ns / 1ps
module hhs_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

/* rtl/core/heavy_hitter_sketch_insert.sv */
// Top level of the heavy-hitter sketch insert and bucket read block.
// channel | signals                               | direction
// in      | in_valid/in_ready, func..col_sel      | request into block
// out     | out_valid/out_ready, bucket_item/count| read result out
// cfg     | cfg_valid/cfg_ready, cfg_index/data   | register write
// A read passes through S_RD and S_RDW; its result is registered as S_RDW ends when the output
// register is free, else the read waits in S_RDW until the pending result leaves.
// An insert holds the block through S_H1, where the key multiply steps once, then per row
// four hash steps, a serial remainder by the row size in S_MOD and a read-modify-write.
// After reset a clearing pass writes every bucket with in_ready low.
`timescale 1ns / 1ps
module heavy_hitter_sketch_insert
    import hhs_pkg::*;
#(
    parameter int NUM_ROWS = 4,
    parameter int MAX_ROW_SIZE = 1024,
    parameter int NUM_SKETCHES = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        func,
    input  logic [1:0]  sketch_sel,
    input  logic [31:0] item_value,
    input  logic [1:0]  row_sel,
    input  logic [9:0]  col_sel,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] bucket_item,
    output logic [31:0] bucket_count,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    localparam int CW = $clog2(MAX_ROW_SIZE);
    localparam int SKW = (NUM_SKETCHES > 1) ? $clog2(NUM_SKETCHES) : 1;
    localparam int RW = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1;
    localparam int DEPTH = NUM_SKETCHES * NUM_ROWS * MAX_ROW_SIZE;
    localparam int AW = $clog2(DEPTH);
    localparam int SZW = CW + 1;

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE = 4'd1;
    localparam logic [3:0] S_RD = 4'd2;
    localparam logic [3:0] S_RDW = 4'd3;
    localparam logic [3:0] S_H1 = 4'd4;
    localparam logic [3:0] S_H2 = 4'd5;
    localparam logic [3:0] S_H3 = 4'd6;
    localparam logic [3:0] S_H4 = 4'd7;
    localparam logic [3:0] S_H5 = 4'd8;
    localparam logic [3:0] S_MOD = 4'd9;
    localparam logic [3:0] S_RMW_R = 4'd10;
    localparam logic [3:0] S_RMW_W = 4'd11;

    logic [3:0]      state_reg, state_next;
    logic [AW-1:0]   clr_reg;
    logic [10:0]     row_size_reg;
    logic [31:0]     seed_reg [4];
    logic [31:0]     item_reg;
    logic [SKW-1:0]  sk_reg;
    logic [RW-1:0]   row_reg;
    logic [31:0]     h_reg, k_reg;
    logic [31:0]     rem_reg, quo_reg;
    logic [5:0]      step_reg;
    logic [SZW-1:0]  rs_reg;
    logic [CW-1:0]   col_reg;
    logic            out_valid_reg;
    bucket_t         out_reg;
    logic            rd_zero_reg;

    logic            we, re;
    logic [AW-1:0]   waddr, raddr;
    bucket_t         wdata, rdata;
    logic [31:0]     rotk, hm, seedr, rem_sh;
    logic [SZW-1:0]  rs_eff;
    logic            rd_ok;
    logic [AW-1:0]   rd_addr, rmw_addr;

    hhs_ram #(.WIDTH(64), .DEPTH(DEPTH)) u_ram (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
        .re(re), .raddr(raddr), .rdata(rdata)
    );

    assign in_ready = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign bucket_item = out_reg.item;
    assign bucket_count = out_reg.count;

    always_comb
    begin
        if (row_size_reg == 11'd0)
        begin
            rs_eff = SZW'(1);
        end
        else if ({21'd0, row_size_reg} > 32'(MAX_ROW_SIZE))
        begin
            rs_eff = SZW'(MAX_ROW_SIZE);
        end
        else
        begin
            rs_eff = SZW'(row_size_reg);
        end
    end

    assign rd_ok = (32'(sketch_sel) < 32'(NUM_SKETCHES)) && (32'(row_sel) < 32'(NUM_ROWS))
                   && (32'(col_sel) < 32'(MAX_ROW_SIZE));
    assign rd_addr = AW'(((32'(sketch_sel) * 32'(NUM_ROWS)) + 32'(row_sel))
                     * 32'(MAX_ROW_SIZE) + 32'(col_sel));
    assign rmw_addr = AW'(((32'(sk_reg) * 32'(NUM_ROWS)) + 32'(row_reg))
                      * 32'(MAX_ROW_SIZE) + 32'(col_reg));
    assign seedr = seed_reg[row_reg];
    assign rotk = {k_reg[16:0], k_reg[31:17]};
    assign hm = {h_reg[18:0], h_reg[31:19]};
    assign rem_sh = {rem_reg[30:0], quo_reg[31]};

    always_comb
    begin
        we = 1'b0;
        waddr = rmw_addr;
        wdata = rdata;
        re = 1'b0;
        raddr = rmw_addr;
        if (state_reg == S_CLEAR)
        begin
            we = 1'b1;
            waddr = clr_reg;
            wdata = '0;
        end
        else if (state_reg == S_IDLE)
        begin
            re = in_valid && in_ready && (func == FUNC_READ);
            raddr = rd_addr;
        end
        else if (state_reg == S_RMW_R)
        begin
            re = 1'b1;
        end
        else if (state_reg == S_RMW_W)
        begin
            we = 1'b1;
            if (rdata.item == item_reg)
            begin
                wdata.count = (rdata.count == COUNT_MAX) ? COUNT_MAX : rdata.count + 32'd1;
            end
            else if (rdata.count > 32'd1)
            begin
                wdata.count = rdata.count - 32'd1;
            end
            else
            begin
                wdata.item = item_reg;
                wdata.count = 32'd1;
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (clr_reg == AW'(DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    if (func == FUNC_READ)
                    begin
                        state_next = S_RD;
                    end
                    else if (32'(sketch_sel) < 32'(NUM_SKETCHES))
                    begin
                        state_next = S_H1;
                    end
                end
            end
            S_RD: state_next = S_RDW;
            S_RDW:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            S_H1: state_next = S_H2;
            S_H2: state_next = S_H3;
            S_H3: state_next = S_H4;
            S_H4: state_next = S_H5;
            S_H5: state_next = S_MOD;
            S_MOD:
            begin
                if (step_reg == 6'd32)
                begin
                    state_next = S_RMW_R;
                end
            end
            S_RMW_R: state_next = S_RMW_W;
            S_RMW_W:
            begin
                if (32'(row_reg) == 32'(NUM_ROWS - 1))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_H2;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg <= '0;
            out_valid_reg <= 1'b0;
            row_size_reg <= 11'd1024;
            for (int i = 0; i < 4; i++)
            begin
                seed_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_CLEAR)
            begin
                clr_reg <= clr_reg + AW'(1);
            end
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_ROW_SIZE)
                begin
                    row_size_reg <= cfg_data[10:0];
                end
                else if (cfg_index >= REG_SEED0 && cfg_index <= REG_SEED3)
                begin
                    seed_reg[2'(cfg_index - REG_SEED0)] <= cfg_data;
                end
            end
            if (state_reg == S_RDW && (!out_valid_reg || out_ready))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_valid && in_ready)
        begin
            item_reg <= item_value;
            sk_reg <= SKW'(sketch_sel);
            row_reg <= '0;
            rd_zero_reg <= !rd_ok;
            k_reg <= item_value * C1;
            rs_reg <= rs_eff;
        end
        unique case (state_reg)
            S_H1:
            begin
                k_reg <= rotk * C2;
            end
            S_H2:
            begin
                h_reg <= seedr ^ k_reg;
            end
            S_H3:
            begin
                h_reg <= hm * 32'd5 + C3;
            end
            S_H4:
            begin
                h_reg <= (h_reg ^ (h_reg >> 16)) * C4;
            end
            S_H5:
            begin
                quo_reg <= ((h_reg ^ (h_reg >> 13)) * C5)
                           ^ (((h_reg ^ (h_reg >> 13)) * C5) >> 16);
                rem_reg <= '0;
                step_reg <= '0;
            end
            S_MOD:
            begin
                if (step_reg != 6'd32)
                begin
                    if (rem_sh >= 32'(rs_reg))
                    begin
                        rem_reg <= rem_sh - 32'(rs_reg);
                    end
                    else
                    begin
                        rem_reg <= rem_sh;
                    end
                    quo_reg <= {quo_reg[30:0], 1'b0};
                    step_reg <= step_reg + 6'd1;
                end
                else
                begin
                    col_reg <= CW'(rem_reg);
                end
            end
            S_RMW_W:
            begin
                row_reg <= row_reg + RW'(1);
            end
            S_RDW:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_reg <= rd_zero_reg ? '0 : rdata;
                end
            end
            default:
            begin
            end
        endcase
    end
endmodule

/* rtl/core/hhs_checker.sv */
// Port-level assertions for the heavy-hitter sketch insert block and their bind.
`timescale 1ns / 1ps
module hhs_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        func,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] bucket_item
);
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(bucket_item))
        else $error("result dropped or changed while stalled");
    a_read_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && func |-> ##3 out_valid)
        else $error("read result missing");
    a_insert_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !func && !out_valid |=> !out_valid)
        else $error("insert produced a result");
endmodule

bind heavy_hitter_sketch_insert hhs_checker u_hhs_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready), .func(func),
    .out_valid(out_valid), .out_ready(out_ready), .bucket_item(bucket_item)
);
